// ----- src/button_press_repeat_tracker_macros.svh -----
// Assertion macros used by the checker file of the button repeat tracker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BUTTON_PRESS_REPEAT_TRACKER_MACROS_SVH
`define BUTTON_PRESS_REPEAT_TRACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define BPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent, outside reset.
`define BPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the cycle after reset is sampled active.
`define BPR_ASSERT_AFTER_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) \
        (!i_rst_n) |=> (cons)) else $error(msg);

`endif

// ----- src/bpr_pkg.sv -----
// Package for the button repeat tracker: field widths, codes, item structs.
// No dependencies; every module of the block imports it.
package bpr_pkg;

    localparam int TIME_W = 48;
    localparam int BTN_W  = 4;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Operation codes carried in the input tuser.
    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TICK    = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // Button codes that the repeat logic cares about.
    localparam logic [BTN_W-1:0] BTN_RIGHT = 4'd3;
    localparam logic [BTN_W-1:0] BTN_A     = 4'd4;
    localparam logic [BTN_W-1:0] BTN_B     = 4'd5;

    // Event action codes.
    localparam logic ACT_PRESSED  = 1'b0;
    localparam logic ACT_RELEASED = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;

    localparam logic [CFG_W-1:0] INITIAL_DELAY_RST   = 16'd400;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

    typedef struct packed {
        t_op               op;
        logic [BTN_W-1:0]  button;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic              valid;
        logic [BTN_W-1:0]  button;
        logic              action;
    } t_event;

    // Time plus a delay, saturating at the largest time value.
    function automatic logic [TIME_W-1:0] sat_add_time(
        input logic [TIME_W-1:0] t,
        input logic [CFG_W-1:0]  d
    );
        logic [TIME_W:0] s;
        s = {1'b0, t} + {{(TIME_W+1-CFG_W){1'b0}}, d};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

// ----- src/bpr_in_stage.sv -----
// Input register of the button repeat tracker: holds one accepted transaction.
// Depends on bpr_pkg for the item struct.
module bpr_in_stage
    import bpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;

    // Free when empty or when the held item moves on in this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, loaded on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- src/bpr_core.sv -----
// Held-button state, repeat timer and event decision of the repeat tracker.
// Depends on bpr_pkg for codes, structs and the saturating time add.
module bpr_core
    import bpr_pkg::*;
#(
    parameter int NUM_BUTTONS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_item            i_item,
    input  logic [CFG_W-1:0] i_initial_delay,
    input  logic [CFG_W-1:0] i_repeat_interval,
    output t_event           o_event
);

    localparam int IDX_W = $clog2(NUM_BUTTONS);

    logic [NUM_BUTTONS-1:0] r_held,     n_held;
    logic                   r_armed,    n_armed;
    logic [BTN_W-1:0]       r_target,   n_target;
    logic [TIME_W-1:0]      r_deadline, n_deadline;

    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic              held_b;
    logic              is_dir;
    logic              due;
    logic [TIME_W-1:0] press_deadline;
    logic [TIME_W-1:0] next_deadline;

    // Decode the item against the current state.
    assign idx      = i_item.button[IDX_W-1:0];
    assign in_range = {1'b0, i_item.button} < (BTN_W+1)'(NUM_BUTTONS);
    assign held_b   = in_range && r_held[idx];
    assign is_dir   = i_item.button <= BTN_RIGHT;
    assign due      = i_item.now_ms >= r_deadline;

    assign press_deadline = sat_add_time(i_item.now_ms, i_initial_delay);
    assign next_deadline  = sat_add_time(i_item.now_ms, i_repeat_interval);

    // Next state and the event for this item.
    always_comb begin
        n_held     = r_held;
        n_armed    = r_armed;
        n_target   = r_target;
        n_deadline = r_deadline;
        o_event    = '0;
        case (i_item.op)
            OP_PRESS: begin
                if (in_range && !held_b) begin
                    n_held[idx]    = 1'b1;
                    o_event.valid  = 1'b1;
                    o_event.button = i_item.button;
                    o_event.action = ACT_PRESSED;
                    if (is_dir) begin
                        n_armed    = 1'b1;
                        n_target   = i_item.button;
                        n_deadline = press_deadline;
                    end
                end
            end
            OP_RELEASE: begin
                if (held_b) begin
                    n_held[idx]    = 1'b0;
                    o_event.valid  = 1'b1;
                    o_event.button = i_item.button;
                    o_event.action = ACT_RELEASED;
                    if (i_item.button == r_target || i_item.button == BTN_A ||
                        i_item.button == BTN_B) begin
                        n_armed = 1'b0;
                    end
                end
            end
            OP_TICK: begin
                if (r_armed && due) begin
                    n_deadline     = next_deadline;
                    o_event.valid  = 1'b1;
                    o_event.button = r_target;
                    o_event.action = ACT_PRESSED;
                end
            end
            OP_CLEAR: begin
                n_held  = '0;
                n_armed = 1'b0;
            end
            default: begin
                n_held = r_held;
            end
        endcase
    end

    // State registers advance once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_armed    <= 1'b0;
            r_target   <= '0;
            r_deadline <= '0;
        end else if (i_fire) begin
            r_held     <= n_held;
            r_armed    <= n_armed;
            r_target   <= n_target;
            r_deadline <= n_deadline;
        end
    end

endmodule

// ----- src/bpr_out_stage.sv -----
// Result register of the button repeat tracker: holds one event until taken.
// Depends on bpr_pkg for the event struct.
module bpr_out_stage
    import bpr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_event i_event,
    output logic   o_valid,
    input  logic   i_ready,
    output t_event o_event
);

    logic   r_valid;
    t_event r_event;

    assign o_valid = r_valid;
    assign o_event = r_event;

    // Valid flag: set by an item that yields an event, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_event.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_load && i_event.valid) begin
            r_event <= i_event;
        end
    end

endmodule

// ----- src/button_press_repeat_tracker.sv -----
// Each accepted input transaction is held in the input register, moves through the core
// when the result register is free, and its event is offered from the result register.
// Throughput: one input transaction per cycle while the sink takes events; the input
// register and the result register let a new item in while an event waits, and the
// only stall is a full result register that the sink does not take.
// Reset (synchronous, active low) empties both registers, clears all held buttons and
// the repeat timer, and loads the delays with 400 ms and 100 ms.
module button_press_repeat_tracker
    import bpr_pkg::*;
#(
    parameter int NUM_BUTTONS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input items.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,  // [3:0] button, [51:4] now_ms, rest zero
    input  logic [1:0]           s_axis_tuser,  // [1:0] operation
    // Events.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [3:0] event_button, rest zero
    output logic [0:0]           m_axis_tuser,  // [0] event_action
    // Configuration writes.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_initial_delay;
    logic [CFG_W-1:0] r_repeat_interval;

    t_item  in_item;
    t_item  cur_item;
    logic   cur_valid;
    logic   out_valid;
    logic   take;
    t_event core_event;
    t_event out_event;

    // Configuration registers accept a write every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_delay   <= INITIAL_DELAY_RST;
            r_repeat_interval <= REPEAT_INTERVAL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INITIAL_DELAY:   r_initial_delay   <= i_cfg_data;
                REG_REPEAT_INTERVAL: r_repeat_interval <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Unpack the input transaction.
    assign in_item.op     = t_op'(s_axis_tuser);
    assign in_item.button = s_axis_tdata[BTN_W-1:0];
    assign in_item.now_ms = s_axis_tdata[BTN_W+TIME_W-1:BTN_W];

    // The held item moves through the core when the result register can take it.
    assign take = cur_valid && (!out_valid || m_axis_tready);

    bpr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (cur_valid),
        .o_item  (cur_item),
        .i_take  (take)
    );

    bpr_core #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (take),
        .i_item            (cur_item),
        .i_initial_delay   (r_initial_delay),
        .i_repeat_interval (r_repeat_interval),
        .o_event           (core_event)
    );

    bpr_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_event (core_event),
        .o_valid (out_valid),
        .i_ready (m_axis_tready),
        .o_event (out_event)
    );

    // Pack the event transaction.
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {4'b0000, out_event.button};
    assign m_axis_tuser  = out_event.action;

endmodule

// ----- src/bpr_checker.sv -----
// Port-level checks for the button repeat tracker, bound to its top level.
// Depends on bpr_pkg and the assertion macros header.
`include "button_press_repeat_tracker_macros.svh"

module bpr_checker
    import bpr_pkg::*;
#(
    parameter int NUM_BUTTONS = 10
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [7:0]           m_axis_tdata,
    input logic [0:0]           m_axis_tuser
);

    logic       out_stall;
    logic       out_free;
    logic       out_btn_ok;
    logic [9:0] out_word;

    // Views of the master side used by the checks below.
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_free   = !m_axis_tvalid || m_axis_tready;
    assign out_word   = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};
    assign out_btn_ok = (m_axis_tdata[7:4] == 4'd0) &&
                        ({1'b0, m_axis_tdata[3:0]} < 5'(NUM_BUTTONS));

    // A stalled event stays valid and keeps its contents.
    `BPR_ASSERT_NEXT(a_out_hold, out_stall, $stable(out_word), "stalled event changed")

    // Every event names a real button and the padding stays zero.
    `BPR_ASSERT_SAME(a_out_button, m_axis_tvalid, out_btn_ok, "event button out of range")

    // The input side never stalls unless an event is stuck at the output.
    `BPR_ASSERT_SAME(a_in_ready, out_free, s_axis_tready, "input stalled with a free output")

    // No event is offered right after reset.
    `BPR_ASSERT_AFTER_RESET(a_rst_empty, !m_axis_tvalid, "event valid after reset")

endmodule

bind button_press_repeat_tracker bpr_checker #(
    .NUM_BUTTONS (NUM_BUTTONS)
) u_bpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- test/button_press_repeat_tracker_tb.sv -----
// Self-checking testbench for button_press_repeat_tracker: a directed table, then random
// press, release, tick and clear traffic under several delay settings, with random idling.
// Depends on bpr_pkg and the block RTL; expected events come from a local model or the rows.
module button_press_repeat_tracker_tb;
    import bpr_pkg::*;

    localparam int NUM_BUTTONS = 10;
    localparam int CLK_HALF = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 300;
    localparam longint TIMEOUT = 64'd3_200_000;
    localparam int N_DIRECTED = 25;
    localparam int EXP_DEPTH = 4096;

    // Button codes used by the directed table.
    localparam logic [BTN_W-1:0] BTN_UP     = 4'd0;
    localparam logic [BTN_W-1:0] BTN_DOWN   = 4'd1;
    localparam logic [BTN_W-1:0] BTN_LEFT   = 4'd2;
    localparam logic [BTN_W-1:0] BTN_START  = 4'd9;
    localparam logic [BTN_W-1:0] BTN_BAD_LO = 4'd10;
    localparam logic [BTN_W-1:0] BTN_BAD_HI = 4'd15;

    typedef struct packed {
        logic [BTN_W-1:0] button;
        logic             action;
    } t_key_event;

    // One row of the directed table; typed rows carry their own expected event.
    typedef struct packed {
        t_op               op;
        logic [BTN_W-1:0]  button;
        logic [TIME_W-1:0] now_ms;
        logic              typed;
        logic              fires;
        logic [BTN_W-1:0]  ev_button;
        logic              ev_action;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [55:0]          s_axis_tdata = '0;  // [3:0] button, [51:4] now_ms, rest zero
    logic [1:0]           s_axis_tuser = '0;  // [1:0] operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;       // [3:0] event_button, rest zero
    logic [0:0]           m_axis_tuser;       // [0] event_action
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Tracker state mirrored by the testbench.
    logic [15:0]       held_mask;
    logic              rep_armed;
    logic [BTN_W-1:0]  rep_target;
    logic [TIME_W-1:0] rep_deadline;
    logic [CFG_W-1:0]  cur_delay;
    logic [CFG_W-1:0]  cur_interval;

    // Expected events in order, written by the stimulus and read by the checker.
    t_key_event exp_fifo [EXP_DEPTH];
    int         exp_wr = 0;
    int         exp_rd = 0;
    int         error_count = 0;
    bit         idle_enabled = 1'b1;
    bit         hold_request = 1'b0;
    int         hold_left = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{OP_TICK,    BTN_UP,     48'd0,             1'b1, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_PRESS,   BTN_UP,     48'd1000,          1'b1, 1'b1, BTN_UP,    ACT_PRESSED},
        '{OP_TICK,    BTN_UP,     48'd1399,          1'b0, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_TICK,    BTN_UP,     48'd1400,          1'b0, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_PRESS,   BTN_UP,     48'd1450,          1'b1, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_TICK,    BTN_DOWN,   48'd1499,          1'b0, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_TICK,    BTN_DOWN,   48'd1500,          1'b0, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_RELEASE, BTN_DOWN,   48'd0,             1'b1, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_PRESS,   BTN_A,      48'd1600,          1'b1, 1'b1, BTN_A,     ACT_PRESSED},
        '{OP_RELEASE, BTN_A,      48'd0,             1'b1, 1'b1, BTN_A,     ACT_RELEASED},
        '{OP_TICK,    BTN_UP,     48'd9000,          1'b0, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_PRESS,   BTN_BAD_LO, 48'd0,             1'b1, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_RELEASE, BTN_BAD_HI, 48'd0,             1'b1, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_PRESS,   BTN_RIGHT,  TIME_MAX - 48'd5,  1'b1, 1'b1, BTN_RIGHT, ACT_PRESSED},
        '{OP_TICK,    BTN_UP,     TIME_MAX - 48'd1,  1'b0, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_TICK,    BTN_UP,     TIME_MAX,          1'b0, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_TICK,    BTN_BAD_HI, TIME_MAX,          1'b0, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_PRESS,   BTN_B,      48'd0,             1'b1, 1'b1, BTN_B,     ACT_PRESSED},
        '{OP_PRESS,   BTN_START,  48'd0,             1'b1, 1'b1, BTN_START, ACT_PRESSED},
        '{OP_RELEASE, BTN_B,      48'd0,             1'b1, 1'b1, BTN_B,     ACT_RELEASED},
        '{OP_TICK,    BTN_UP,     TIME_MAX,          1'b0, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_PRESS,   BTN_LEFT,   48'h5555_5555_5555, 1'b1, 1'b1, BTN_LEFT, ACT_PRESSED},
        '{OP_CLEAR,   BTN_BAD_HI, TIME_MAX,          1'b1, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_RELEASE, BTN_START,  48'd0,             1'b1, 1'b0, BTN_UP,    ACT_PRESSED},
        '{OP_RELEASE, BTN_LEFT,   48'd0,             1'b1, 1'b0, BTN_UP,    ACT_PRESSED}
    };

    button_press_repeat_tracker #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Time plus a delay, clamped at the largest time value.
    function automatic logic [TIME_W-1:0] clamp_add(input logic [TIME_W-1:0] t,
                                                    input logic [31:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, t} + {17'b0, d};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // Applies one item to the mirrored state and returns whether it raises an event.
    function automatic bit advance_tracker(input t_op op, input logic [BTN_W-1:0] btn,
                                           input logic [TIME_W-1:0] now,
                                           output t_key_event ev);
        ev = '0;
        case (op)
            OP_PRESS: begin
                if (btn >= NUM_BUTTONS || held_mask[btn])
                    return 1'b0;
                held_mask[btn] = 1'b1;
                // Directions arm the repeat timer.
                if (btn <= BTN_RIGHT) begin
                    rep_armed = 1'b1;
                    rep_target = btn;
                    rep_deadline = clamp_add(now, {16'b0, cur_delay});
                end
                ev = '{btn, ACT_PRESSED};
                return 1'b1;
            end
            OP_RELEASE: begin
                if (btn >= NUM_BUTTONS || !held_mask[btn])
                    return 1'b0;
                held_mask[btn] = 1'b0;
                if (rep_armed && (btn == rep_target || btn == BTN_A || btn == BTN_B))
                    rep_armed = 1'b0;
                ev = '{btn, ACT_RELEASED};
                return 1'b1;
            end
            OP_TICK: begin
                if (!rep_armed || now < rep_deadline)
                    return 1'b0;
                rep_deadline = clamp_add(now, {16'b0, cur_interval});
                ev = '{rep_target, ACT_PRESSED};
                return 1'b1;
            end
            default: begin
                held_mask = '0;
                rep_armed = 1'b0;
                return 1'b0;
            end
        endcase
    endfunction

    // Appends one event to the expected list.
    task automatic note_event(input t_key_event ev);
        exp_fifo[exp_wr % EXP_DEPTH] = ev;
        exp_wr++;
    endtask

    // Queues the event, if any, that an accepted item should produce.
    task automatic track_item(input t_op op, input logic [BTN_W-1:0] btn,
                              input logic [TIME_W-1:0] now);
        t_key_event ev;
        if (advance_tracker(op, btn, now, ev))
            note_event(ev);
    endtask

    // Offers one item, with random gaps ahead of it, and returns once it is taken.
    task automatic send_item(input t_op op, input logic [BTN_W-1:0] btn,
                             input logic [TIME_W-1:0] now);
        while (idle_enabled && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, now, btn};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stops offering items and waits until every expected event has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both delay registers back to back; only called while the block is idle.
    task automatic write_delays(input logic [CFG_W-1:0] delay_ms,
                                input logic [CFG_W-1:0] interval_ms);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_INITIAL_DELAY;
        i_cfg_data  <= delay_ms;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_delay = delay_ms;
        i_cfg_index <= REG_REPEAT_INTERVAL;
        i_cfg_data  <= interval_ms;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_interval = interval_ms;
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic on a mostly rising time line so that repeat deadlines are reached.
    task automatic run_random_phase(input int n_items, input logic [CFG_W-1:0] delay_ms,
                                    input logic [CFG_W-1:0] interval_ms,
                                    input logic [TIME_W-1:0] start_ms, input bit jitter,
                                    input int hold_at, input int pause_at);
        logic [TIME_W-1:0] cursor;
        logic [TIME_W-1:0] now;
        logic [BTN_W-1:0]  btn;
        t_op               op;
        int                span;
        int                roll;
        write_delays(delay_ms, interval_ms);
        idle_enabled = jitter;
        cursor = start_ms;
        span = (int'(delay_ms) + int'(interval_ms)) / 8 + 2;
        for (int k = 0; k < n_items; k++) begin
            if (k == hold_at)
                hold_request = 1'b1;
            if (k == pause_at)
                wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 30)
                op = OP_PRESS;
            else if (roll < 56)
                op = OP_RELEASE;
            else if (roll < 96)
                op = OP_TICK;
            else
                op = OP_CLEAR;
            if (op == OP_TICK || op == OP_CLEAR || $urandom_range(0, 99) < 8)
                btn = 4'($urandom_range(0, 15));
            else
                btn = 4'($urandom_range(0, NUM_BUTTONS - 1));
            cursor = clamp_add(cursor, $urandom_range(0, span));
            // A few items carry an unrelated time stamp.
            if ($urandom_range(0, 99) < 3)
                now = 48'({$urandom, $urandom});
            else
                now = cursor;
            send_item(op, btn, now);
            track_item(op, btn, now);
        end
        wait_drained();
    endtask

    // Sink pacing: random stalls, plus one long hold-off when requested.
    always @(posedge i_clk) begin : sink_pacing
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !idle_enabled || ($urandom_range(0, 99) >= 9);
        end
    end

    // Compares each event transaction with the oldest expected event.
    always @(posedge i_clk) begin : event_check
        t_key_event want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_wr == exp_rd) begin
                $error("unexpected event: button %0d action %0d",
                       m_axis_tdata[3:0], m_axis_tuser[0]);
                error_count++;
            end else begin
                want = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_axis_tdata[3:0] !== want.button) begin
                    $error("event_button: expected %0d, actual %0d",
                           want.button, m_axis_tdata[3:0]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.action) begin
                    $error("event_action: expected %0d, actual %0d",
                           want.action, m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT);
        $display("button_press_repeat_tracker_tb failed");
        $finish;
    end

    initial begin : stimulus
        t_key_event dummy;
        t_stim_row  row;
        held_mask    = '0;
        rep_armed    = 1'b0;
        rep_target   = '0;
        rep_deadline = '0;
        cur_delay    = INITIAL_DELAY_RST;
        cur_interval = REPEAT_INTERVAL_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under the reset delays.
        for (int r = 0; r < N_DIRECTED; r++) begin
            row = directed_rows[r];
            send_item(row.op, row.button, row.now_ms);
            if (row.typed) begin
                void'(advance_tracker(row.op, row.button, row.now_ms, dummy));
                if (row.fires)
                    note_event(t_key_event'{row.ev_button, row.ev_action});
            end else begin
                track_item(row.op, row.button, row.now_ms);
            end
        end
        wait_drained();

        // Random phases: reset values, both extremes, a zero interval, saturation, random.
        run_random_phase(300, 16'd400, 16'd100, 48'd0, 1'b0, -1, -1);
        run_random_phase(250, 16'd0, 16'd1, 48'({$urandom, $urandom}), 1'b1, 60, -1);
        run_random_phase(250, 16'hFFFF, 16'hFFFF, 48'({$urandom, $urandom}), 1'b1, -1, 125);
        run_random_phase(200, 16'd0, 16'd0, 48'({$urandom, $urandom}), 1'b1, -1, -1);
        run_random_phase(200, 16'($urandom), 16'($urandom), TIME_MAX - 48'd200000, 1'b1,
                         -1, -1);
        run_random_phase(400, 16'($urandom_range(0, 3000)), 16'($urandom_range(1, 2000)),
                         48'({$urandom, $urandom}), 1'b1, 200, -1);

        if (error_count == 0)
            $display("button_press_repeat_tracker_tb passed");
        else
            $display("button_press_repeat_tracker_tb failed");
        $finish;
    end

endmodule
